// ===== sv/murmur_hash_64a_macros.svh =====
// assertion macros for the murmur_hash_64a checker
// depends on nothing; the checker supplies clk and rst_n
`ifndef MURMUR_HASH_64A_MACROS_SVH
`define MURMUR_HASH_64A_MACROS_SVH

// implication in the same cycle, checked outside reset
`define MMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, checked outside reset
`define MMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mmh64a_pkg.sv =====
// shared types and constants of the murmur_hash_64a block
// depends on nothing
package mmh64a_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;
  localparam logic [63:0] HASH_SEED = 64'hdeadbeefdeadbeef;

  // default number of words held between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // what a word contributes to the hash
  typedef enum logic [1:0] {
    ABS_NONE,
    ABS_PART,
    ABS_FULL
  } absorb_t;

  // one classified word as it travels through the queue
  typedef struct packed {
    logic        seed;
    logic [30:0] len;
    absorb_t     kind;
    logic [63:0] data;
    logic        fin;
  } cmd_t;

  // phases of the shared multiplier
  typedef enum logic [1:0] {
    PH_LL,
    PH_HL,
    PH_LH
  } mul_phase_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEED,
    BK_MIX1,
    BK_MIX2,
    BK_FOLD,
    BK_FIN,
    BK_EMIT
  } back_state_t;

endpackage

// ===== sv/mmh64a_front.sv =====
// front end: accepts input words, masks the bytes and classifies each word
// depends on mmh64a_pkg
module mmh64a_front import mmh64a_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_is_first,
  input  logic        in_is_last,
  input  logic [30:0] in_message_length,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  logic [63:0] masked;

  // stall only while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // keep only the bytes below the byte count
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = (4'(b) < in_word_bytes) ? in_word[b*8 +: 8] : 8'd0;
    end
  end

  // classify the word
  always_comb begin
    q_data.seed = in_is_first;
    q_data.len  = in_message_length;
    q_data.fin  = in_is_last;
    if (in_word_bytes inside {[4'd8:4'd15]}) begin
      q_data.kind = ABS_FULL;
      q_data.data = in_word;
    end else if (in_word_bytes == 4'd0) begin
      q_data.kind = ABS_NONE;
      q_data.data = masked;
    end else begin
      q_data.kind = ABS_PART;
      q_data.data = masked;
    end
  end

endmodule

// ===== sv/mmh64a_queue.sv =====
// short queue of classified words between front and back
// depends on mmh64a_pkg
module mmh64a_queue import mmh64a_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/mmh64a_mul.sv =====
// shared multiplier: low 64 bits of a times the mix constant, three 32x32 passes
// depends on mmh64a_pkg
module mmh64a_mul import mmh64a_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0] a_r;
  logic [63:0] acc_r;
  mul_phase_t  ph_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] opx, opy;
  logic [63:0] prod;

  // operand selection for the current pass
  always_comb begin
    case (ph_r)
      PH_LL: begin
        opx = a_r[31:0];
        opy = MIX_MUL[31:0];
      end
      PH_HL: begin
        opx = a_r[63:32];
        opy = MIX_MUL[31:0];
      end
      PH_LH: begin
        opx = a_r[31:0];
        opy = MIX_MUL[63:32];
      end
      default: begin
        opx = a_r[31:0];
        opy = MIX_MUL[31:0];
      end
    endcase
  end

  assign prod = 64'(opx) * 64'(opy);

  // pass sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_LL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= PH_LL;
      end else if (busy_r) begin
        case (ph_r)
          PH_LL:   ph_r <= PH_HL;
          PH_HL:   ph_r <= PH_LH;
          PH_LH: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
          default: busy_r <= 1'b0;
        endcase
      end
    end
  end

  // operand and partial product accumulation
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
    end else if (busy_r) begin
      if (ph_r == PH_LL) begin
        acc_r <= prod;
      end else begin
        acc_r[63:32] <= acc_r[63:32] + prod[31:0];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// ===== sv/mmh64a_back.sv =====
// back end: runs seed, word mix, fold and final avalanche on the shared multiplier
// depends on mmh64a_pkg and mmh64a_mul
module mmh64a_back import mmh64a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);

  back_state_t state_r, state_nxt;
  logic [63:0] h_r, h_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  cmd_t        cur;
  logic        out_free;
  logic        enter_abs, enter_fin;
  logic [63:0] h_abs, h_fin, t_mix;

  mmh64a_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign cur      = (state_r == BK_IDLE) ? q_head : cmd_r;
  assign t_mix    = mrsp.p ^ (mrsp.p >> MIX_SHIFT);

  // sequencer: next state, multiplier requests and result hand-off
  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hash_nxt  = out_hash_r;
    q_pop         = 1'b0;
    mreq.start    = 1'b0;
    mreq.a        = 64'(cur.len);
    enter_abs     = 1'b0;
    enter_fin     = 1'b0;
    h_abs         = h_r;
    h_fin         = h_r;

    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          if (q_head.seed) begin
            mreq.start = 1'b1;
            mreq.a     = 64'(q_head.len);
            state_nxt  = BK_SEED;
          end else begin
            enter_abs = 1'b1;
          end
        end
      end
      BK_SEED: begin
        if (mrsp.done) begin
          enter_abs = 1'b1;
          h_abs     = HASH_SEED ^ mrsp.p;
        end
      end
      BK_MIX1: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = t_mix;
          state_nxt  = BK_MIX2;
        end
      end
      BK_MIX2: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = h_r ^ mrsp.p;
          state_nxt  = BK_FOLD;
        end
      end
      BK_FOLD: begin
        if (mrsp.done) begin
          enter_fin = 1'b1;
          h_fin     = mrsp.p;
        end
      end
      BK_FIN: begin
        if (mrsp.done) begin
          h_nxt = t_mix;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_hash_nxt  = t_mix;
            state_nxt     = BK_IDLE;
          end else begin
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = h_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    // absorb the word into the current hash
    if (enter_abs) begin
      case (cur.kind)
        ABS_FULL: begin
          h_nxt      = h_abs;
          mreq.start = 1'b1;
          mreq.a     = cur.data;
          state_nxt  = BK_MIX1;
        end
        ABS_PART: begin
          h_nxt      = h_abs ^ cur.data;
          mreq.start = 1'b1;
          mreq.a     = h_abs ^ cur.data;
          state_nxt  = BK_FOLD;
        end
        default: begin
          enter_fin = 1'b1;
          h_fin     = h_abs;
        end
      endcase
    end

    // finish the message or go back for the next word
    if (enter_fin) begin
      h_nxt = h_fin;
      if (cur.fin) begin
        mreq.start = 1'b1;
        mreq.a     = h_fin ^ (h_fin >> MIX_SHIFT);
        state_nxt  = BK_FIN;
      end else begin
        state_nxt = BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// ===== sv/murmur_hash_64a.sv =====
// MurmurHash64A engine, seed 0xdeadbeefdeadbeef.
// Input channel (in_valid / in_stall): one word per item, up to eight
// little-endian message bytes, with byte count, first and last marks and
// the message length (sampled on the first word).
// Output channel (out_valid / out_stall): one 64-bit hash per word marked last.
// The front end classifies and masks each word and writes it into a short
// queue; the back end pops it and works it through one shared multiplier
// that forms each 64-bit product in three 32x32 passes. A full word needs
// three products, a partial word one, a first word one more, a last word
// one more for the final avalanche; a word with no bytes and no marks needs
// no product. Throughput is therefore set by the multiplier.
// The finished hash sits in an output register; the back end keeps working
// on following words while it waits and only holds when a second hash is due.
// in_stall is high only while the queue is full.
// Reset (rst_n low, synchronous) empties the queue, drops any pending hash
// and clears the running hash to zero.
// depends on mmh64a_pkg, mmh64a_front, mmh64a_queue, mmh64a_back
module murmur_hash_64a import mmh64a_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_is_first,
  input  logic        in_is_last,
  input  logic [30:0] in_message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);

  logic q_full, q_push, q_pop, q_not_empty;
  cmd_t q_data, q_head;

  mmh64a_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_word           (in_word),
    .in_word_bytes     (in_word_bytes),
    .in_is_first       (in_is_first),
    .in_is_last        (in_is_last),
    .in_message_length (in_message_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_data)
  );

  mmh64a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mmh64a_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

// ===== sv/mmh64a_checker.sv =====
// port-level checks on murmur_hash_64a, bound to the top level
// depends on murmur_hash_64a_macros.svh
`include "murmur_hash_64a_macros.svh"

module mmh64a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_hash_value
);

  // a stalled hash word stays offered and unchanged
  `MMH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out word dropped while stalled")
  `MMH_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_hash_value), "out word changed while stalled")

  // right after reset the queue is empty and no hash is pending
  `MMH_ASSERT_NOW(a_reset_clean, $rose(rst_n), !in_stall && !out_valid, "state left over from reset")

  // the queue only fills up after a word was taken
  `MMH_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid && !in_stall), "stall without a preceding word")

endmodule

bind murmur_hash_64a mmh64a_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hash_value (out_hash_value)
);

// ===== dv/murmur_hash_64a_checker.sv =====
// checker for murmur_hash_64a: follows both channels, predicts each hash
// and compares it with what comes out; depends on mmh64a_pkg for the constants
module murmur_hash_64a_checker import mmh64a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_is_first,
  input  logic        in_is_last,
  input  logic [30:0] in_message_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_hash_value,
  output int          fail_count,
  output int          hashes_due
);

  // predicted hash in progress and the finished hashes still to come
  logic [63:0] hash_acc;
  logic [63:0] due_hashes[$];
  logic [63:0] want;

  initial begin
    fail_count = 0;
    hashes_due = 0;
    hash_acc   = 64'd0;
  end

  // multiply, shift-xor, multiply on one full word
  function automatic logic [63:0] scramble(input logic [63:0] k);
    logic [63:0] t;
    t = k * MIX_MUL;
    t = t ^ (t >> MIX_SHIFT);
    return t * MIX_MUL;
  endfunction

  // closing avalanche applied on the last word
  function automatic logic [63:0] avalanche(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> MIX_SHIFT);
    t = t * MIX_MUL;
    return t ^ (t >> MIX_SHIFT);
  endfunction

  // fold one word into the running hash, seeding it first where marked
  function automatic logic [63:0] absorb(input logic [63:0] acc, input logic [63:0] data,
                                         input logic [3:0] nb, input logic lead,
                                         input logic [30:0] len);
    logic [63:0] h;
    logic [63:0] keep;
    h = lead ? (HASH_SEED ^ ({33'd0, len} * MIX_MUL)) : acc;
    if (nb >= 4'd8) begin
      h = (h ^ scramble(data)) * MIX_MUL;
    end else if (nb != 4'd0) begin
      keep = (64'd1 << (8 * nb)) - 64'd1;
      h = (h ^ (data & keep)) * MIX_MUL;
    end
    return h;
  endfunction

  task automatic report(input string what);
    fail_count++;
    $display("[%0t] hash check: %s", $time, what);
  endtask

  // compare accepted hashes first, then take in the accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      hash_acc = 64'd0;
      due_hashes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_hashes.size() == 0) begin
          report($sformatf("hash %h with none expected", out_hash_value));
        end else begin
          want = due_hashes.pop_front();
          if (out_hash_value !== want)
            report($sformatf("hash_value %h, expected %h", out_hash_value, want));
        end
      end
      if (in_valid && !in_stall) begin
        hash_acc = absorb(hash_acc, in_word, in_word_bytes, in_is_first, in_message_length);
        if (in_is_last) begin
          hash_acc = avalanche(hash_acc);
          due_hashes = {due_hashes, hash_acc};
        end
      end
    end
    hashes_due = due_hashes.size();
  end

endmodule

// ===== dv/tb_murmur_hash_64a.sv =====
// top of the murmur_hash_64a testbench: clock, reset, word stimulus, stalls
// and the verdict; depends on murmur_hash_64a and murmur_hash_64a_checker
module tb_murmur_hash_64a;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_word = 64'd0;
  logic [3:0]  in_word_bytes = 4'd0;
  logic        in_is_first = 1'b0;
  logic        in_is_last = 1'b0;
  logic [30:0] in_message_length = 31'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_value;
  int          fail_count;
  int          hashes_due;

  int words_sent = 0;
  int msg_count = 0;
  bit quiet = 1'b0;
  bit in_calm = 1'b0;

  always #4 clk = ~clk;

  murmur_hash_64a dut (.*);

  murmur_hash_64a_checker chk (.*);

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [30:0] rand_len();
    logic [30:0] l;
    l = 31'($urandom);
    return l;
  endfunction

  // offer one word, with an occasional gap before it, and wait for acceptance
  task automatic push_word(input logic [63:0] w, input logic [3:0] nb, input logic lead,
                           input logic tail, input logic [30:0] len);
    int gap;
    if (!quiet && !in_calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_word           <= w;
    in_word_bytes     <= nb;
    in_is_first       <= lead;
    in_is_last        <= tail;
    in_message_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // a well-formed message of nbytes bytes; a multiple of eight may end
  // either on the full word or on a separate empty word
  task automatic send_message(input int unsigned nbytes, input logic [30:0] declared);
    int unsigned left;
    logic lead;
    left = nbytes;
    lead = 1'b1;
    while (left > 8 || (left == 8 && $urandom_range(0, 1) == 1)) begin
      push_word(rand_word(), 4'd8, lead, 1'b0, lead ? declared : rand_len());
      lead = 1'b0;
      left -= 8;
    end
    push_word(rand_word(), left[3:0], lead, 1'b1, lead ? declared : rand_len());
  endtask

  // hold off the sender until every hash has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hashes_due != 0) @(posedge clk);
  endtask

  // result side stall bursts, calm stretches, none at the end of the run
  initial begin : sink_stall
    int burst;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        burst = $urandom_range(20, 60);
        repeat (burst) @(posedge clk);
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned nbytes;
    logic [30:0] declared;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // words before any first mark continue from the cleared hash
    push_word(rand_word(), 4'd8, 1'b0, 1'b1, rand_len());
    // empty messages, shortest and longest declared length
    push_word(rand_word(), 4'd0, 1'b1, 1'b1, 31'd0);
    push_word(rand_word(), 4'd0, 1'b1, 1'b1, 31'h7fffffff);
    // all ones word, then an empty closing word
    push_word({64{1'b1}}, 4'd8, 1'b1, 1'b0, 31'd8);
    push_word(rand_word(), 4'd0, 1'b0, 1'b1, rand_len());
    push_word(64'd0, 4'd8, 1'b1, 1'b1, 31'd8);
    // every partial size, with garbage in the unused bytes
    for (k = 1; k < 8; k++)
      push_word(rand_word(), k[3:0], 1'b1, 1'b1, k[30:0]);
    // byte counts above eight count as full words
    for (k = 9; k < 16; k++)
      push_word(rand_word(), k[3:0], k == 9, k == 15, 31'd56);
    // partial word mid-message, then an empty word that is not last
    push_word(rand_word(), 4'd3, 1'b1, 1'b0, 31'd8);
    push_word(rand_word(), 4'd0, 1'b0, 1'b0, rand_len());
    push_word(rand_word(), 4'd5, 1'b0, 1'b1, rand_len());
    // carry on from a finished hash without a first mark
    push_word(rand_word(), 4'd8, 1'b0, 1'b1, rand_len());

    // random part: mostly well-formed messages, some noise words
    while (words_sent < 824) begin
      if (words_sent >= 700) quiet = 1'b1;
      if ($urandom_range(0, 7) == 0) in_calm = ~in_calm;
      if (!quiet && msg_count % 60 == 30) drain();
      if ($urandom_range(0, 4) == 0) begin
        push_word(rand_word(), 4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 2) == 0, rand_len());
      end else begin
        k = $urandom_range(0, 19);
        if (k < 14) nbytes = $urandom_range(0, 24);
        else if (k < 19) nbytes = $urandom_range(25, 80);
        else nbytes = $urandom_range(81, 300);
        declared = ($urandom_range(0, 9) == 0) ? rand_len() : nbytes[30:0];
        send_message(nbytes, declared);
      end
      msg_count++;
    end

    drain();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
